### src/spt_pkg.sv
// Package for the procedural sky texel generator: formats, constants and per-stage math.
`default_nettype none

package spt_pkg;

  // Largest face exponent and fraction bits of the output colors
  localparam int MaxLog2Res    = 12;
  localparam int ColorFracBits = 11;
  localparam int VecW          = MaxLog2Res + 2;
  localparam int OutShift      = 16 - ColorFracBits;
  localparam int OutRound      = 1 << (15 - ColorFracBits);

  localparam logic [3:0] ResetLog2Res = 4'd9;

  // Pipeline stage map
  localparam int ProdStage  = 1;
  localparam int SumStage   = 2;
  localparam int IsqStart   = 3;
  localparam int IsqSteps   = 29;
  localparam int RootStage  = IsqStart + IsqSteps;
  localparam int DivStart   = RootStage + 1;
  localparam int DivSteps   = 17;
  localparam int DivEnd     = DivStart + DivSteps;
  localparam int PowStage   = DivEnd + 1;
  localparam int LogStart   = PowStage + 1;
  localparam int LogSteps   = 16;
  localparam int ExpoStage  = LogStart + LogSteps;
  localparam int ExpStart   = ExpoStage + 1;
  localparam int ExpSteps   = 16;
  localparam int TStage     = ExpStart + ExpSteps;
  localparam int MixStage   = TStage + 1;
  localparam int OutStage   = MixStage + 1;
  localparam int NumStages  = OutStage + 1;

  // Sun direction and the exponent and glow gains in Q16; the sun gain is a plain integer
  localparam logic signed [17:0] SunX = -18'sd29429;
  localparam logic signed [17:0] SunY = 18'sd54654;
  localparam logic signed [17:0] SunZ = 18'sd21021;
  localparam logic [16:0] ExpGain  = 17'd22938;
  localparam logic [16:0] GlowGain = 17'd22938;
  localparam logic [4:0]  SunGain  = 5'd18;

  // Palettes in Q16, red in entry 0
  localparam logic [2:0][15:0] SkyLo = {16'd62259, 16'd49152, 16'd42598};
  localparam logic [2:0][15:0] SkyHi = {16'd20972, 16'd7864, 16'd2294};
  localparam logic [2:0][15:0] GndLo = {16'd11141, 16'd12452, 16'd14418};
  localparam logic [2:0][15:0] GndHi = {16'd2621, 16'd1966, 16'd1638};
  localparam logic [2:0][16:0] Tint  = {17'd38011, 17'd53740, 17'd65536};

  typedef enum logic [2:0] {
    FacePx = 3'd0,
    FaceNx = 3'd1,
    FacePy = 3'd2,
    FaceNy = 3'd3,
    FacePz = 3'd4,
    FaceNz = 3'd5
  } face_e;

  // Everything one texel carries down the pipeline
  typedef struct packed {
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [VecW-1:0] vz;
    logic                   neg;
    logic [12:0]            ymag;
    logic [24:0]            sq0;
    logic [24:0]            sq1;
    logic [24:0]            sq2;
    logic signed [31:0]     dp0;
    logic signed [31:0]     dp1;
    logic signed [31:0]     dp2;
    logic signed [31:0]     d;
    logic [58:0]            sq_n;
    logic [58:0]            sq_res;
    logic [28:0]            r;
    logic                   dpos;
    logic                   ovf_y;
    logic                   ovf_a;
    logic [45:0]            rem_y;
    logic [45:0]            rem_a;
    logic [16:0]            q_y;
    logic [16:0]            q_a;
    logic [16:0]            ay;
    logic [16:0]            align;
    logic [4:0]             m;
    logic                   yzero;
    logic [30:0]            z;
    logic [15:0]            frac;
    logic [2:0]             ip;
    logic [15:0]            f;
    logic [30:0]            pres;
    logic [16:0]            t;
    logic [16:0]            p;
    logic [16:0]            p4;
    logic [16:0]            p8;
    logic [16:0]            x;
    logic [16:0]            g;
    logic [20:0]            k;
    logic [2:0][21:0]       tk;
    logic [2:0][32:0]       ma;
    logic [2:0][32:0]       mb;
    logic [2:0][15:0]       rgb;
  } pipe_t;

  // Floor square root, used at elaboration for the exponent coefficients
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bt;
    n   = n_in;
    res = '0;
    for (int j = 0; j < 32; j++) begin
      bt = 64'(1) << (62 - 2 * j);
      if (n >= res + bt) begin
        n   = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Q30 factors 2^-(2^-(16-b)), each from the square root of the previous one
  function automatic logic [ExpSteps-1:0][29:0] exp_coefs();
    logic [ExpSteps-1:0][29:0] tab;
    logic [63:0] c;
    c = isqrt64(64'(1) << 59);
    for (int b = ExpSteps - 1; b >= 0; b--) begin
      tab[b] = c[29:0];
      c = isqrt64(c << 30);
    end
    return tab;
  endfunction

  localparam logic [ExpSteps-1:0][29:0] ExpCoef = exp_coefs();

  // Q16 product with round half up
  function automatic logic [16:0] mulq16(input logic [16:0] a, input logic [16:0] b);
    logic [34:0] pr;
    pr = 35'(a) * 35'(b) + 35'd32768;
    return pr[32:16];
  endfunction

  // Entry stage: mask coordinates, center them and build the face vector
  function automatic pipe_t entry_step(input logic [2:0] face, input logic [11:0] tx_in,
                                       input logic [11:0] ty_in, input logic [3:0] lg_cfg);
    pipe_t y;
    logic [3:0] lg;
    logic [12:0] one_res;
    logic [11:0] mask;
    logic [11:0] tx;
    logic [11:0] ty;
    logic signed [VecW-1:0] res;
    logic signed [VecW-1:0] h;
    logic signed [VecW-1:0] v;
    y       = '0;
    lg      = (lg_cfg > 4'(MaxLog2Res)) ? 4'(MaxLog2Res) : lg_cfg;
    one_res = 13'(1) << lg;
    mask    = 12'(one_res - 13'd1);
    tx      = tx_in & mask;
    ty      = ty_in & mask;
    res     = signed'(VecW'(one_res));
    h       = signed'(VecW'({tx, 1'b1})) - res;
    v       = signed'(VecW'({ty, 1'b1})) - res;
    case (face_e'(face))
      FacePx: begin y.vx = res;  y.vy = -v;   y.vz = -h;   end
      FaceNx: begin y.vx = -res; y.vy = -v;   y.vz = h;    end
      FacePy: begin y.vx = h;    y.vy = res;  y.vz = v;    end
      FaceNy: begin y.vx = h;    y.vy = -res; y.vz = -v;   end
      FacePz: begin y.vx = h;    y.vy = -v;   y.vz = res;  end
      FaceNz: begin y.vx = -h;   y.vy = -v;   y.vz = -res; end
      // unused face codes map to -Z
      default: begin y.vx = -h;  y.vy = -v;   y.vz = -res; end
    endcase
    return y;
  endfunction

  // One pipeline stage; k selects which slice of the math this stage does
  function automatic pipe_t stage_step(input int k, input pipe_t x);
    pipe_t y;
    logic signed [27:0] pr;
    logic [58:0] sbit;
    logic [46:0] numy;
    logic [46:0] numa;
    logic [28:0] rv;
    logic [45:0] dv;
    logic [46:0] zsh;
    logic [61:0] sqz;
    logic [31:0] zt;
    logic [20:0] nl;
    logic [34:0] ev;
    logic [60:0] pm;
    logic [30:0] tsh;
    logic [31:0] tr;
    logic [16:0] tp;
    logic [38:0] tkp;
    logic [16:0] om;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [33:0] mixs;
    logic [23:0] cs;
    logic [23:0] ov;
    int mm;
    int j;
    int b;
    y = x;

    // squares and sun products
    if (k == ProdStage) begin
      pr = x.vx * x.vx;  y.sq0 = pr[24:0];
      pr = x.vy * x.vy;  y.sq1 = pr[24:0];
      pr = x.vz * x.vz;  y.sq2 = pr[24:0];
      y.dp0  = 32'(x.vx) * 32'(SunX);
      y.dp1  = 32'(x.vy) * 32'(SunY);
      y.dp2  = 32'(x.vz) * 32'(SunZ);
      y.neg  = x.vy < 0;
      y.ymag = (x.vy < 0) ? 13'(-x.vy) : 13'(x.vy);
    end

    // squared length and sun dot product
    if (k == SumStage) begin
      y.d      = x.dp0 + x.dp1 + x.dp2;
      y.sq_n   = 59'(26'(x.sq0) + 26'(x.sq1) + 26'(x.sq2)) << 32;
      y.sq_res = '0;
    end

    // one digit of the square root per stage
    if (k >= IsqStart && k < RootStage) begin
      j    = k - IsqStart;
      sbit = 59'(1) << (2 * (IsqSteps - 1) - 2 * j);
      if (x.sq_n >= x.sq_res + sbit) begin
        y.sq_n   = x.sq_n - (x.sq_res + sbit);
        y.sq_res = (x.sq_res >> 1) + sbit;
      end else begin
        y.sq_res = x.sq_res >> 1;
      end
    end

    // set up both divisions by the length and flag quotients of 2^17 and above
    if (k == RootStage) begin
      rv      = x.sq_res[28:0];
      numy    = 47'({x.ymag, 32'b0});
      numa    = 47'({x.d[29:0], 16'b0});
      y.r     = rv;
      y.dpos  = x.d > 0;
      y.ovf_y = numy >= (47'(rv) << DivSteps);
      y.ovf_a = numa >= (47'(rv) << DivSteps);
      y.rem_y = numy[45:0];
      y.rem_a = numa[45:0];
      y.q_y   = '0;
      y.q_a   = '0;
    end

    // one quotient bit per stage for both dividers
    if (k >= DivStart && k < DivEnd) begin
      b  = DivSteps - 1 - (k - DivStart);
      dv = 46'(x.r) << b;
      if (x.rem_y >= dv) begin
        y.rem_y  = x.rem_y - dv;
        y.q_y[b] = 1'b1;
      end
      if (x.rem_a >= dv) begin
        y.rem_a  = x.rem_a - dv;
        y.q_a[b] = 1'b1;
      end
    end

    // cap the height and the sun alignment at one; alignment is zero unless the sun dot product is positive
    if (k == DivEnd) begin
      y.ay    = (x.ovf_y || x.q_y > 17'd65536) ? 17'd65536 : x.q_y;
      y.align = !x.dpos ? 17'd0 :
                (x.ovf_a || x.q_a > 17'd65536) ? 17'd65536 : x.q_a;
    end

    // normalize the height for the log and start the alignment powers
    if (k == PowStage) begin
      mm = 0;
      for (int i = 0; i < 17; i++) begin
        if (x.ay[i]) mm = i;
      end
      zsh     = 47'(x.ay) << (30 - mm);
      y.z     = zsh[30:0];
      y.m     = 5'(mm);
      y.yzero = x.ay == 17'd0;
      y.frac  = '0;
      y.p     = mulq16(x.align, x.align);
    end

    // alignment power chain
    if (k > PowStage && k <= PowStage + 8) y.p = mulq16(x.p, x.p);
    if (k == PowStage + 1) y.p4 = mulq16(x.p, x.p);
    if (k == PowStage + 2) y.p8 = mulq16(x.p, x.p);
    if (k == PowStage + 4) y.g = mulq16(x.p8, x.p);
    if (k == PowStage + 5) y.g = mulq16(x.g, GlowGain);
    if (k == PowStage + 7) y.x = mulq16(x.p4, x.p);
    if (k == PowStage + 8) y.x = mulq16(x.x, x.p);
    if (k == PowStage + 9) y.x = mulq16(x.x, x.p);
    if (k == PowStage + 10) y.k = 21'(x.x) * 21'(SunGain) + 21'(x.g);
    if (k == PowStage + 11) begin
      for (int c = 0; c < 3; c++) begin
        tkp     = 39'(Tint[c]) * 39'(x.k) + 39'd32768;
        y.tk[c] = tkp[37:16];
      end
    end

    // one log fraction bit per stage by squaring
    if (k >= LogStart && k < ExpoStage) begin
      sqz    = 62'(x.z) * 62'(x.z);
      zt     = sqz[61:30];
      y.z    = zt[31] ? zt[31:1] : zt[30:0];
      y.frac = {x.frac[14:0], zt[31]};
    end

    // scale -log2 by 0.35 and split the exponent into integer and fraction
    if (k == ExpoStage) begin
      nl     = (21'(5'd16 - x.m) << 16) - 21'(x.frac);
      ev     = 35'(nl) * 35'(ExpGain) + 35'd32768;
      y.ip   = ev[34:32];
      y.f    = ev[31:16];
      y.pres = 31'(1) << 30;
    end

    // one fraction bit of the exponential per stage
    if (k >= ExpStart && k < TStage) begin
      b = ExpSteps - 1 - (k - ExpStart);
      if (x.f[b]) begin
        pm     = 61'(x.pres) * 61'(ExpCoef[b]) + (61'(1) << 29);
        y.pres = pm[60:30];
      end
    end

    // mix factor: height^0.35 above the horizon, depth below
    if (k == TStage) begin
      tsh = x.pres >> x.ip;
      tr  = 32'(tsh) + 32'(1 << 13);
      tp  = (tr[31:14] > 18'd65536) ? 17'd65536 : tr[30:14];
      if (x.yzero) tp = '0;
      y.t = x.neg ? x.ay : tp;
    end

    // gradient products per channel
    if (k == MixStage) begin
      om = 17'd65536 - x.t;
      for (int c = 0; c < 3; c++) begin
        lo      = x.neg ? GndLo[c] : SkyLo[c];
        hi      = x.neg ? GndHi[c] : SkyHi[c];
        y.ma[c] = 33'(lo) * 33'(om);
        y.mb[c] = 33'(hi) * 33'(x.t);
      end
    end

    // add the sun, round to the output format and saturate
    if (k == OutStage) begin
      for (int c = 0; c < 3; c++) begin
        mixs     = 34'(x.ma[c]) + 34'(x.mb[c]) + 34'd32768;
        cs       = 24'(mixs[32:16]) + 24'(x.tk[c]) + 24'(OutRound);
        ov       = cs >> OutShift;
        y.rgb[c] = (ov > 24'd65535) ? 16'hFFFF : ov[15:0];
      end
    end
    return y;
  endfunction

endpackage

`default_nettype wire

### src/procedural_sky_texel_generator_top.sv
// Top level of the procedural sky texel generator: stream ports and the stage pipeline.
//
// Usage:
//   Slave stream takes one texel address per request; the master stream returns
//   its RGB radiance (unsigned Q5.11 per channel, saturating). A separate write
//   channel sets the face exponent (always ready, take it only while idle).
//   Throughput: one texel per clock when the output is taken every cycle.
//   Depth: set by the 29-step square root, the 17-step shared-divisor
//   division, the 16-round log by squaring and the 16-step exponential
//   product chain, one step a stage.
//   Reset: empties the pipeline and sets the exponent register to 9.
//   Stall: when the receiver drops tready the last stage holds its result;
//   stages behind it keep moving into empty slots, and the input stops only
//   once every stage is occupied. No request is lost or repeated.
`default_nettype none

module procedural_sky_texel_generator_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // face[2:0], texel_x[14:3], texel_y[26:15], zeros
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // red[15:0], green[31:16], blue[47:32]
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_data_i      // log2_resolution
);

  localparam int NS = spt_pkg::NumStages;

  logic [3:0]      log2_res_q;
  logic [NS-1:0]   valid_q;
  logic [NS:0]     stage_adv;
  spt_pkg::pipe_t  data_q [NS];

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_res_q <= spt_pkg::ResetLog2Res;
    end else if (cfg_valid_i) begin
      log2_res_q <= cfg_data_i;
    end
  end

  // A stage may load when it is empty or its content moves on
  always_comb begin
    stage_adv[NS] = m_axis_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      stage_adv[i] = !valid_q[i] || stage_adv[i + 1];
    end
  end

  assign s_axis_tready = stage_adv[0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_adv[0]) valid_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (stage_adv[i]) valid_q[i] <= valid_q[i - 1];
      end
    end
  end

  // Advance payload, one slice of the math per stage
  always_ff @(posedge clk_i) begin
    if (stage_adv[0] && s_axis_tvalid) begin
      data_q[0] <= spt_pkg::entry_step(s_axis_tdata[2:0], s_axis_tdata[14:3],
                                       s_axis_tdata[26:15], log2_res_q);
    end
    for (int i = 1; i < NS; i++) begin
      if (stage_adv[i] && valid_q[i - 1]) begin
        data_q[i] <= spt_pkg::stage_step(i, data_q[i - 1]);
      end
    end
  end

  // Last stage is the output register
  assign m_axis_tvalid = valid_q[NS - 1];
  assign m_axis_tdata  = data_q[NS - 1].rgb;

endmodule

`default_nettype wire

### src/spt_checker.sv
// Port-level checks for the procedural sky texel generator and their binding.
`default_nettype none

module spt_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata,
  input wire        cfg_ready_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // An empty output stage means the pipeline has room
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // Configuration is never refused
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration refused");

  // Reset leaves no result behind
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result right after reset");

endmodule

bind procedural_sky_texel_generator_top spt_checker u_spt_checker (.*);

`default_nettype wire
